/* rtl/dwsp_pkg.sv */
// dwsp_pkg: shared constants and types for the dual wheel speed pid unit
// no dependencies
package dwsp_pkg;

  localparam int unsigned AvgLen  = 5;
  localparam int unsigned SlotW   = $clog2(AvgLen);
  localparam int unsigned PulseW  = 13;
  localparam int unsigned SumW    = PulseW + $clog2(AvgLen + 1);

  // ring average as a reciprocal multiply, exact for any ring sum magnitude
  localparam int unsigned     AvgShift = SumW + $clog2(AvgLen);
  localparam longint unsigned AvgRecip = ((64'd1 << AvgShift) + AvgLen - 1) / AvgLen;
  localparam int unsigned     AvgProdW = 2 * SumW + 1;

  // divide by ten, exact for magnitudes below 2**27
  localparam int unsigned     Div10Shift = 31;
  localparam longint unsigned Div10Recip = ((64'd1 << Div10Shift) + 64'd9) / 64'd10;

  // steering target divides, exact over the ranges that reach them
  localparam int unsigned     OuterShift = 38;
  localparam longint unsigned OuterRecip = ((64'd1 << OuterShift) + 64'd9999) / 64'd10000;
  localparam int unsigned     InnerShift = 53;
  localparam longint unsigned InnerRecip =
    ((64'd1 << InnerShift) + 64'd4999999) / 64'd5000000;
  // anything at or above this gives a target past the cap
  localparam longint unsigned InnerClip  = 64'd201 * 64'd5000000;

  localparam logic [1:0] CfgTarget = 2'd0;
  localparam logic [1:0] CfgGainP  = 2'd1;
  localparam logic [1:0] CfgGainI  = 2'd2;
  localparam logic [1:0] CfgGainD  = 2'd3;

  // per-lane job handed over by the steering stage
  typedef struct packed {
    logic [7:0]  target;   // capped at 200
    logic [11:0] speed;
    logic        halt;
  } lane_job_t;

endpackage

/* rtl/dwsp_avg.sv */
// dwsp_avg: moving average ring and absolute speed for one wheel
// depends on dwsp_pkg
module dwsp_avg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_i,
  input  logic [dwsp_pkg::SlotW-1:0] slot_i,
  input  logic signed [12:0]         pulses_i,
  output logic [11:0]                speed_o
);
  import dwsp_pkg::*;

  logic signed [PulseW-1:0] ring_q [AvgLen];
  logic signed [SumW-1:0]   sum;
  logic [SumW-1:0]          mag;
  logic [AvgProdW-1:0]      prod;
  logic [SumW-1:0]          quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < AvgLen; k++) ring_q[k] <= '0;
    end else if (wr_i) begin
      ring_q[slot_i] <= pulses_i;
    end
  end

  // the ring is read in the cycle after the write
  // |sum / len| truncated toward zero equals floor(|sum| / len)
  always_comb begin
    sum = '0;
    for (int k = 0; k < AvgLen; k++) sum = sum + SumW'(ring_q[k]);
    mag  = sum[SumW-1] ? SumW'(-sum) : SumW'(sum);
    prod = AvgProdW'(mag) * AvgProdW'(AvgRecip);
    quo  = SumW'(prod >> AvgShift);
    speed_o = (quo > SumW'(4095)) ? 12'd4095 : quo[11:0];
  end
endmodule

/* rtl/dwsp_pid.sv */
// dwsp_pid: positional pid lane, one wheel, takes a new request only while idle
// depends on dwsp_pkg
module dwsp_pid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  dwsp_pkg::lane_job_t job_i,
  input  logic [11:0]         gain_p_i,
  input  logic [11:0]         gain_i_i,
  input  logic [11:0]         gain_d_i,
  output logic                done_o,
  output logic [12:0]         drive_o
);
  import dwsp_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StSum  = 2'd3;

  logic [1:0] st_q, st_d;
  logic signed [15:0] err_q, integ_q, integ_raw_q;
  logic signed [15:0] derr_q;
  logic signed [31:0] p_q, i_q, d_q;
  logic signed [31:0] p_div_q, i_div_q, d_div_q;
  logic [12:0] drive_q;
  logic signed [15:0] e_new, integ_sum;
  logic signed [31:0] p_t, i_t, dsum;

  // divide by ten truncating toward zero, magnitude below 2**27
  function automatic logic signed [31:0] div10(input logic signed [31:0] x);
    logic [26:0] mag;
    logic [54:0] prod;
    logic [31:0] quo;
    mag  = x[31] ? 27'(-x) : 27'(x);
    prod = 55'(mag) * 55'(Div10Recip);
    quo  = 32'(prod >> Div10Shift);
    return x[31] ? -signed'(quo) : signed'(quo);
  endfunction

  assign e_new     = 16'(signed'({1'b0, job_i.target})) - 16'(signed'({1'b0, job_i.speed}));
  assign integ_sum = integ_q + e_new;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (start_i && !job_i.halt) st_d = StMul;
      StMul:  st_d = StDiv;
      StDiv:  st_d = StSum;
      StSum:  st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // cap the scaled p and i terms from above, then sum them with the d term
  always_comb begin
    p_t = p_div_q;
    if (p_t > 32'sd5000) p_t = 32'sd5000;
    i_t = i_div_q;
    if (i_t > 32'sd3000) i_t = 32'sd3000;
    dsum = p_t + i_t + d_div_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      err_q       <= '0;
      integ_q     <= '0;
      integ_raw_q <= '0;
      derr_q      <= '0;
      p_q         <= '0;
      i_q         <= '0;
      d_q         <= '0;
      p_div_q     <= '0;
      i_div_q     <= '0;
      d_div_q     <= '0;
      drive_q     <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == StIdle && start_i) begin
        if (job_i.halt) begin
          integ_q <= '0;
          drive_q <= '0;
        end else begin
          derr_q      <= e_new - err_q;
          err_q       <= e_new;
          integ_raw_q <= integ_sum;
          integ_q     <= (integ_sum > 16'sd5000) ? 16'sd5000 :
                         (integ_sum < -16'sd5000) ? -16'sd5000 : integ_sum;
        end
      end
      if (st_q == StMul) begin
        p_q <= 32'(signed'({1'b0, gain_p_i})) * 32'(err_q);
        i_q <= 32'(signed'({1'b0, gain_i_i})) * 32'(integ_raw_q);
        d_q <= 32'(signed'({1'b0, gain_d_i})) * 32'(derr_q);
      end
      if (st_q == StDiv) begin
        p_div_q <= div10(p_q);
        i_div_q <= div10(i_q);
        d_div_q <= div10(d_q);
      end
      if (st_q == StSum) begin
        drive_q <= (dsum > 32'sd8000) ? 13'd8000 :
                   (dsum < 32'sd1000) ? 13'd1000 : dsum[12:0];
      end
    end
  end

  assign done_o  = (st_q == StIdle);
  assign drive_o = drive_q;

  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drive_q == 13'd0) || (drive_q >= 13'd1000 && drive_q <= 13'd8000))
    else $error("drive out of range");
  a_integ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    integ_q <= 16'sd5000 && integ_q >= -16'sd5000) else $error("integral clamp");
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StMul |=> st_q == StDiv) else $error("pid sequence");
endmodule

/* rtl/dual_wheel_speed_pid_unit.sv */
// dual_wheel_speed_pid_unit: top level, steering targets and two pid lanes
// depends on dwsp_pkg, dwsp_avg, dwsp_pid
//
// usage:
//  - one request on in_valid_i/in_ready_o carries both encoder counts, the
//    steering value and the halt flag; one result leaves on out_valid_o/
//    out_ready_i with both drives and both filtered speeds
//  - a request goes from accept to result valid through the ring write,
//    averaging and target products, inner product and outer divide, inner
//    divide and caps, then four pid lane steps (load, gain multiply, divide
//    by ten, sum and clamp) and the merge into the output register; the two
//    wheel lanes run side by side; a halted request skips the gain multiply,
//    divide and sum steps of the lanes
//  - one request is worked on at a time; the next is taken once the result
//    register is loaded, while that result still waits for its receiver
//  - a stalled receiver holds the result; a second item finishes and waits
//    in its lanes until the output register frees up
//  - reset clears the rings, slot, errors, integrals and loads default
//    gains; configuration writes apply at once and belong in idle periods
//  - halt gives zero drives and clears both integrals; speeds still update
module dual_wheel_speed_pid_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [12:0] left_pulses_i,
  input  logic signed [12:0] right_pulses_i,
  input  logic [11:0]        steer_value_i,
  input  logic               halt_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [12:0]        left_drive_o,
  output logic [12:0]        right_drive_o,
  output logic [11:0]        left_speed_o,
  output logic [11:0]        right_speed_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [11:0]        cfg_data_i
);
  import dwsp_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StAvg  = 3'd1;
  localparam logic [2:0] StTgt  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StPid  = 3'd4;
  localparam logic [2:0] StWait = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0] st_q, st_d;
  logic [9:0]  tgt_q;
  logic [11:0] gp_q, gi_q, gd_q;
  logic [SlotW-1:0] slot_q;
  logic [11:0] steer_q;
  logic        halt_q;
  logic [11:0] lspd, rspd, lspd_q, rspd_q;
  logic        accept;

  // steering factor and target products
  logic [11:0] dev;
  logic signed [15:0] factor;
  logic [8:0]  inner_k;
  logic        turn_l, turn_r;
  logic [23:0] outer_prod_q;   // t*factor
  logic [18:0] inner_prod_q;   // t*(500-d)
  logic [32:0] inner_full_q;   // t*(500-d)*factor
  logic [9:0]  outer_quo_q;
  logic [7:0]  ltgt, rtgt, ltgt_q, rtgt_q;
  logic        lane_go;
  logic        l_done, r_done;
  logic [12:0] l_drv, r_drv;
  lane_job_t   l_job, r_job;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (st_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= 10'd160; gp_q <= 12'd500; gi_q <= 12'd15; gd_q <= 12'd500;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTarget: tgt_q <= cfg_data_i[9:0];
        CfgGainP:  gp_q  <= cfg_data_i;
        CfgGainI:  gi_q  <= cfg_data_i;
        CfgGainD:  gd_q  <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // averaging lanes
  dwsp_avg u_avg_l (.clk_i, .rst_ni, .wr_i(accept), .slot_i(slot_q),
                    .pulses_i(left_pulses_i), .speed_o(lspd));
  dwsp_avg u_avg_r (.clk_i, .rst_ni, .wr_i(accept), .slot_i(slot_q),
                    .pulses_i(right_pulses_i), .speed_o(rspd));

  // factor is only used in the turn ranges, where it is positive and fits 14 bits
  always_comb begin
    dev    = (steer_q >= 12'd1490) ? steer_q - 12'd1490 : 12'd1490 - steer_q;
    factor = (dev < 12'd80) ? 16'sd10000 : 16'sd11080 - 16'(28 * dev);
    turn_l = (steer_q > 12'd1530) && (steer_q <= 12'd1630);
    turn_r = (steer_q < 12'd1450) && (steer_q >= 12'd1350);
    inner_k = 9'(12'd500 - dev);
  end

  // targets from registered products by reciprocal multiply, all positive
  logic [48:0] outer_mul;
  logic [29:0] inner_clip;
  logic [60:0] inner_mul;
  logic [7:0]  inner_quo;
  logic [7:0]  outer_t, inner_t;
  always_comb begin
    outer_mul  = 49'(outer_prod_q) * 49'(OuterRecip);
    inner_clip = (inner_full_q >= 33'(InnerClip)) ? 30'(InnerClip) : inner_full_q[29:0];
    inner_mul  = 61'(inner_clip) * 61'(InnerRecip);
    inner_quo  = 8'(inner_mul >> InnerShift);
    outer_t = (outer_quo_q > 10'd200) ? 8'd200 : outer_quo_q[7:0];
    inner_t = (inner_quo > 8'd200) ? 8'd200 : inner_quo;
    ltgt = (tgt_q > 10'd200) ? 8'd200 : tgt_q[7:0];
    rtgt = ltgt;
    if (turn_l) begin
      ltgt = inner_t; rtgt = outer_t;
    end else if (turn_r) begin
      rtgt = inner_t; ltgt = outer_t;
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (in_valid_i) st_d = StAvg;
      StAvg:  st_d = StTgt;
      StTgt:  st_d = StDiv;
      StDiv:  st_d = StPid;
      StPid:  st_d = StWait;
      StWait: if (l_done && r_done) st_d = StOut;
      StOut:  if (!out_valid_o || out_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  logic out_valid_q;
  logic [12:0] ld_q, rd_q;
  logic [11:0] ls_q, rs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; slot_q <= '0; out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (accept) begin
        slot_q <= (slot_q == SlotW'(AvgLen - 1)) ? '0 : slot_q + 1'b1;
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (st_q == StOut && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      steer_q <= steer_value_i;
      halt_q  <= halt_i;
    end
    if (st_q == StAvg) begin
      lspd_q <= lspd; rspd_q <= rspd;
      outer_prod_q <= 24'(tgt_q) * 24'(factor[13:0]);
      inner_prod_q <= 19'(tgt_q) * 19'(inner_k);
    end
    if (st_q == StTgt) begin
      inner_full_q <= 33'(inner_prod_q) * 33'(factor[13:0]);
      outer_quo_q  <= 10'(outer_mul >> OuterShift);
    end
    if (st_q == StDiv) begin
      ltgt_q <= ltgt; rtgt_q <= rtgt;
    end
    if (st_q == StOut && (!out_valid_q || out_ready_i)) begin
      ld_q <= l_drv; rd_q <= r_drv; ls_q <= lspd_q; rs_q <= rspd_q;
    end
  end

  assign lane_go = (st_q == StPid);
  assign l_job = '{target: ltgt_q, speed: lspd_q, halt: halt_q};
  assign r_job = '{target: rtgt_q, speed: rspd_q, halt: halt_q};

  dwsp_pid u_pid_l (.clk_i, .rst_ni, .start_i(lane_go), .job_i(l_job),
    .gain_p_i(gp_q), .gain_i_i(gi_q), .gain_d_i(gd_q), .done_o(l_done), .drive_o(l_drv));
  dwsp_pid u_pid_r (.clk_i, .rst_ni, .start_i(lane_go), .job_i(r_job),
    .gain_p_i(gp_q), .gain_i_i(gi_q), .gain_d_i(gd_q), .done_o(r_done), .drive_o(r_drv));

  assign out_valid_o   = out_valid_q;
  assign left_drive_o  = ld_q;
  assign right_drive_o = rd_q;
  assign left_speed_o  = ls_q;
  assign right_speed_o = rs_q;

  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q < SlotW'(AvgLen)) else $error("slot out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(ld_q)) else $error("result lost");
  a_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    l_done == r_done) else $error("lanes out of step");
endmodule
